// ----- sv/dense_key_value_table_assert.svh -----
// ----------------------------------------------------------------------------
// dense_key_value_table_assert.svh
// Assertion macros shared by the dense key/value table modules.
// ----------------------------------------------------------------------------
`ifndef DENSE_KEY_VALUE_TABLE_ASSERT_SVH
`define DENSE_KEY_VALUE_TABLE_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define DKVT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check a consequence in the same cycle as its trigger.
`define DKVT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its trigger.
`define DKVT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/dkvt_pkg.sv -----
// ----------------------------------------------------------------------------
// dkvt_pkg
// Shared sizes, operation and status codes, controller states and commands.
// ----------------------------------------------------------------------------
package dkvt_pkg;

  // Table size and derived widths
  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int WORD_W   = 32;
  localparam int OCC_W    = 5;

  // Operation codes
  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_GET    = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DONE
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;   // register request and lookup result
    logic execute;   // update table, read values
    logic finish;    // finish move, load result registers
  } ctl_cmd_t;

endpackage

// ----- sv/dkvt_ctrl.sv -----
// ----------------------------------------------------------------------------
// dkvt_ctrl
// Sequencer for one request at a time: capture, execute, finish. Owns both
// handshakes and the result valid flag.
// ----------------------------------------------------------------------------
`include "dense_key_value_table_assert.svh"

module dkvt_ctrl import dkvt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output ctl_cmd_t  cmd
);

  state_t state;
  state_t state_next;
  logic   rsp_free;

  // Result register can take a new result this cycle
  assign rsp_free = !rsp_valid || !rsp_stall;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (rsp_free) state_next = req_valid ? S_EXEC : S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd       = '0;
    req_stall = 1'b1;
    unique case (state)
      S_IDLE: begin
        req_stall   = 1'b0;
        cmd.capture = req_valid;
      end
      S_EXEC: begin
        cmd.execute = 1'b1;
      end
      S_DONE: begin
        req_stall   = !rsp_free;
        cmd.finish  = rsp_free;
        cmd.capture = rsp_free && req_valid;
      end
      default: begin
        req_stall = 1'b1;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Result valid: set on finish, drop after transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.finish) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  `DKVT_SAME(a_accept_captures, req_valid && !req_stall, cmd.capture, "accept without capture")
  `DKVT_NEXT(a_capture_executes, cmd.capture, cmd.execute, "capture not followed by execute")
  `DKVT_NEXT(a_finish_shows_result, cmd.finish, rsp_valid, "finish did not raise valid")

endmodule

// ----- sv/dkvt_dp.sv -----
// ----------------------------------------------------------------------------
// dkvt_dp
// Table storage and operation datapath: parallel key compare with priority
// pick, packed entry lanes, value memory with two read ports, result regs.
// ----------------------------------------------------------------------------
`include "dense_key_value_table_assert.svh"

module dkvt_dp import dkvt_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  ctl_cmd_t                 cmd,
  input  logic        [1:0]        mode,
  input  logic signed [WORD_W-1:0] key_a,
  input  logic signed [WORD_W-1:0] key_b,
  input  logic signed [WORD_W-1:0] value_a,
  input  logic signed [WORD_W-1:0] value_b,
  output logic        [1:0]        status,
  output logic signed [WORD_W-1:0] found_a,
  output logic signed [WORD_W-1:0] found_b,
  output logic        [OCC_W-1:0]  occupied
);

  // Entry lanes and count
  logic [WORD_W-1:0]   lane_key_a [CAPACITY];
  logic [WORD_W-1:0]   lane_key_b [CAPACITY];
  logic [CAPACITY-1:0] valid;
  logic [CNT_W-1:0]    total;

  // Value memory, both words side by side
  logic [2*WORD_W-1:0] value_mem [CAPACITY];
  logic [2*WORD_W-1:0] rd_hit;
  logic [2*WORD_W-1:0] rd_last;

  // Captured request
  logic [1:0]          req_mode;
  logic [WORD_W-1:0]   req_key_a;
  logic [WORD_W-1:0]   req_key_b;
  logic [2*WORD_W-1:0] req_value;
  logic                hit_found;
  logic [IDX_W-1:0]    hit_idx;

  // Execute results
  logic [1:0]          res_status;
  logic                res_show;
  logic                res_move;

  // Combinational
  logic                match_found;
  logic [IDX_W-1:0]    match_idx;
  logic                is_full;
  logic [IDX_W-1:0]    free_idx;
  logic [IDX_W-1:0]    last_idx;
  logic                add_new;
  logic                add_upd;
  logic                rem;
  logic                move_wr;
  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  logic [2*WORD_W-1:0] mem_wdata;
  logic [1:0]          exec_status;
  logic                exec_show;

  // Compare every valid lane, keep the lowest match
  always_comb begin
    match_found = 1'b0;
    match_idx   = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (valid[i] && lane_key_a[i] == key_a && lane_key_b[i] == key_b) begin
        match_found = 1'b1;
        match_idx   = IDX_W'(i);
      end
    end
  end

  // Capture request with its lookup result
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_mode  <= mode;
      req_key_a <= key_a;
      req_key_b <= key_b;
      req_value <= {value_a, value_b};
      hit_found <= match_found;
      hit_idx   <= match_idx;
    end
  end

  // Entries stay packed: first free slot is the count, last valid is count-1
  assign is_full  = total >= CNT_W'(CAPACITY);
  assign free_idx = total[IDX_W-1:0];
  assign last_idx = IDX_W'(total - CNT_W'(1));

  assign add_new = cmd.execute && req_mode == MODE_ADD && !hit_found && !is_full;
  assign add_upd = cmd.execute && req_mode == MODE_ADD && hit_found;
  assign rem     = cmd.execute && req_mode == MODE_REMOVE && hit_found;
  assign move_wr = cmd.finish && res_move;

  // Status and value return for the executing request
  always_comb begin
    exec_status = ST_DONE;
    exec_show   = 1'b0;
    unique case (req_mode)
      MODE_ADD: begin
        if (!hit_found && is_full) exec_status = ST_FULL;
      end
      MODE_REMOVE, MODE_GET: begin
        exec_status = hit_found ? ST_DONE : ST_MISSING;
        exec_show   = hit_found;
      end
      default: begin
        exec_status = ST_DONE;
      end
    endcase
  end

  // Value memory write port: add in execute, moved value in finish
  assign mem_we    = add_new || add_upd || move_wr;
  assign mem_waddr = add_new ? free_idx : hit_idx;
  assign mem_wdata = move_wr ? rd_last : req_value;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      value_mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.execute) begin
      rd_hit  <= value_mem[hit_idx];
      rd_last <= value_mem[last_idx];
    end
  end

  // Key lanes: fill the free slot, or pull the last entry into the hole
  always_ff @(posedge clk) begin
    if (add_new) begin
      lane_key_a[free_idx] <= req_key_a;
      lane_key_b[free_idx] <= req_key_b;
    end else if (rem) begin
      lane_key_a[hit_idx] <= lane_key_a[last_idx];
      lane_key_b[hit_idx] <= lane_key_b[last_idx];
    end
  end

  // Valid bits and count
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      total <= '0;
    end else if (add_new) begin
      valid[free_idx] <= 1'b1;
      total           <= total + CNT_W'(1);
    end else if (rem) begin
      valid[last_idx] <= 1'b0;
      total           <= total - CNT_W'(1);
    end
  end

  // Hold execute outcome until finish
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      res_status <= exec_status;
      res_show   <= exec_show;
      res_move   <= rem;
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status   <= res_status;
      found_a  <= res_show ? rd_hit[2*WORD_W-1:WORD_W] : '0;
      found_b  <= res_show ? rd_hit[WORD_W-1:0] : '0;
      occupied <= OCC_W'(total);
    end
  end

  `DKVT_ALWAYS(a_total_bound, total <= CNT_W'(CAPACITY), "entry count above capacity")
  `DKVT_ALWAYS(a_valid_count, $countones(valid) == int'(total), "valid bits disagree with count")
  `DKVT_NEXT(a_remove_shrinks, rem, total == $past(total) - CNT_W'(1), "remove did not shrink")

endmodule

// ----- sv/dense_key_value_table.sv -----
// ----------------------------------------------------------------------------
// dense_key_value_table
// Packed key/value table with add, remove and get, one result per request.
// Steps: the lookup is registered at the request transfer, the execute step
// updates the table, then the finish step loads the result registers.
// A new request is taken with the finish step of the last one, after the
// execute step has updated the table; a stalled result holds it off.
// Reset: synchronous, clears valid bits, count and handshake state.
// ----------------------------------------------------------------------------
module dense_key_value_table import dkvt_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     req_valid,
  output logic                     req_stall,
  input  logic        [1:0]        mode,
  input  logic signed [WORD_W-1:0] key_a,
  input  logic signed [WORD_W-1:0] key_b,
  input  logic signed [WORD_W-1:0] value_a,
  input  logic signed [WORD_W-1:0] value_b,
  output logic                     rsp_valid,
  input  logic                     rsp_stall,
  output logic        [1:0]        status,
  output logic signed [WORD_W-1:0] found_a,
  output logic signed [WORD_W-1:0] found_b,
  output logic        [OCC_W-1:0]  occupied
);

  ctl_cmd_t cmd;

  // Sequencer
  dkvt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd)
  );

  // Table and result datapath
  dkvt_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .mode     (mode),
    .key_a    (key_a),
    .key_b    (key_b),
    .value_a  (value_a),
    .value_b  (value_b),
    .status   (status),
    .found_a  (found_a),
    .found_b  (found_b),
    .occupied (occupied)
  );

endmodule
